/* hw/rtl/drc_pkg.sv */
package drc_pkg;

    localparam int DRC_MAX_RECTS  = 32;
    localparam int DRC_COORD_BITS = 16;
    localparam int DRC_CFG_W      = 15;
    localparam int DRC_CFG_IDX_W  = 2;

    localparam logic [DRC_CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 2'd0;
    localparam logic [DRC_CFG_IDX_W-1:0] CFG_CLIP_TOP    = 2'd1;
    localparam logic [DRC_CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 2'd2;
    localparam logic [DRC_CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 2'd3;

    localparam logic [DRC_CFG_W-1:0] CLIP_LEFT_RST   = 15'd0;
    localparam logic [DRC_CFG_W-1:0] CLIP_TOP_RST    = 15'd0;
    localparam logic [DRC_CFG_W-1:0] CLIP_RIGHT_RST  = 15'd640;
    localparam logic [DRC_CFG_W-1:0] CLIP_BOTTOM_RST = 15'd480;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

endpackage

/* hw/rtl/drc_in_if.sv */
interface drc_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] rect_left;
    logic signed [COORD_BITS-1:0] rect_top;
    logic signed [COORD_BITS-1:0] rect_right;
    logic signed [COORD_BITS-1:0] rect_bottom;

    modport source (output valid, cmd, rect_left, rect_top, rect_right, rect_bottom,
                    input ready);
    modport sink (input valid, cmd, rect_left, rect_top, rect_right, rect_bottom,
                  output ready);
endinterface

/* hw/rtl/drc_out_if.sv */
interface drc_out_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_left;
    logic signed [COORD_BITS-1:0] out_top;
    logic signed [COORD_BITS-1:0] out_right;
    logic signed [COORD_BITS-1:0] out_bottom;
    logic                         is_empty;
    logic                         overflowed;
    logic                         is_last;

    modport source (output valid, out_left, out_top, out_right, out_bottom, is_empty,
                    overflowed, is_last, input ready);
    modport sink (input valid, out_left, out_top, out_right, out_bottom, is_empty,
                  overflowed, is_last, output ready);
endinterface

/* hw/rtl/dirty_rect_coalescer.sv */
// Collects dirty rectangles and, on a flush item, emits a merged and clipped list of
// areas to redraw, the last one marked; an empty store gives one empty item and an
// overflowed store one item with the clip window. A flush walks the rectangle memory
// through its single read port under a small sequencer: merge passes repeat until one
// merges nothing, a containment pass follows, and each result waits for the sink.
// No item is accepted during a flush.
module dirty_rect_coalescer
    import drc_pkg::*;
#(
    parameter int MAX_RECTS  = DRC_MAX_RECTS,
    parameter int COORD_BITS = DRC_COORD_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [DRC_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DRC_CFG_W-1:0]     i_cfg_data,
    drc_in_if.sink                   i_in,
    drc_out_if.source                o_out
);

    localparam int SW = COORD_BITS + 1;
    localparam int KW = (SW > DRC_CFG_W + 1) ? SW : DRC_CFG_W + 1;
    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);

    typedef struct packed {
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] b;
    } t_rect;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_LI   = 12'b000000000010,
        S_LI2  = 12'b000000000100,
        S_LJ   = 12'b000000001000,
        S_MJ   = 12'b000000010000,
        S_CI   = 12'b000000100000,
        S_CI2  = 12'b000001000000,
        S_CJ   = 12'b000010000000,
        S_HJ   = 12'b000100000000,
        S_EI   = 12'b001000000000,
        S_EI2  = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } t_state;

    function automatic logic signed [KW-1:0] low_clip(logic signed [KW-1:0] x,
            logic signed [KW-1:0] lo, logic signed [KW-1:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic logic signed [KW-1:0] high_clip(logic signed [KW-1:0] x,
            logic signed [KW-1:0] lo, logic signed [KW-1:0] hi);
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    t_state                  r_state, n_state;
    logic [DRC_CFG_W-1:0]    r_clip_l, r_clip_t, r_clip_r, r_clip_b;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_ovf, n_ovf;
    logic [4*COORD_BITS-1:0] r_last_add, n_last_add;
    logic [CW-1:0]           r_n, n_n;
    logic [CW-1:0]           r_i, n_i;
    logic [CW-1:0]           r_j, n_j;
    logic [CW-1:0]           r_live_end, n_live_end;
    logic                    r_again, n_again;
    logic [MAX_RECTS-1:0]    r_dead, n_dead;
    t_rect                   r_cur, n_cur;
    t_rect                   r_rd;
    logic                    r_o_valid, n_o_valid;
    logic [COORD_BITS-1:0]   r_o_l, r_o_t, r_o_r, r_o_b;
    logic [COORD_BITS-1:0]   n_o_l, n_o_t, n_o_r, n_o_b;
    logic                    r_o_empty, n_o_empty, r_o_ovf, n_o_ovf, r_o_last, n_o_last;

    t_rect                   mem [MAX_RECTS];
    logic                    mem_we;
    logic [IW-1:0]           mem_wa, mem_ra;
    t_rect                   mem_wd;

    t_rect                   add_rect, merged;
    logic [4*COORD_BITS-1:0] in_raw;
    logic                    in_acc, meets, holds;
    logic signed [KW-1:0]    k_cl, k_ct, k_cr, k_cb, k_l, k_t, k_r, k_b;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign in_raw     = {i_in.rect_left, i_in.rect_top, i_in.rect_right, i_in.rect_bottom};

    assign add_rect.l = {i_in.rect_left[COORD_BITS-1], i_in.rect_left};
    assign add_rect.t = {i_in.rect_top[COORD_BITS-1], i_in.rect_top};
    assign add_rect.r = {i_in.rect_right[COORD_BITS-1], i_in.rect_right} + SW'(1);
    assign add_rect.b = {i_in.rect_bottom[COORD_BITS-1], i_in.rect_bottom} + SW'(1);

    assign meets = (r_cur.l < r_rd.r) && (r_rd.l < r_cur.r) &&
                   (r_cur.t < r_rd.b) && (r_rd.t < r_cur.b);
    assign holds = (r_cur.l <= r_rd.l) && (r_rd.r <= r_cur.r) &&
                   (r_cur.t <= r_rd.t) && (r_rd.b <= r_cur.b);

    assign merged.l = (r_rd.l < r_cur.l) ? r_rd.l : r_cur.l;
    assign merged.t = (r_rd.t < r_cur.t) ? r_rd.t : r_cur.t;
    assign merged.r = (r_rd.r > r_cur.r) ? r_rd.r : r_cur.r;
    assign merged.b = (r_rd.b > r_cur.b) ? r_rd.b : r_cur.b;

    assign k_cl = $signed({{(KW-DRC_CFG_W){1'b0}}, r_clip_l});
    assign k_ct = $signed({{(KW-DRC_CFG_W){1'b0}}, r_clip_t});
    assign k_cr = $signed({{(KW-DRC_CFG_W){1'b0}}, r_clip_r});
    assign k_cb = $signed({{(KW-DRC_CFG_W){1'b0}}, r_clip_b});
    assign k_l  = low_clip(KW'(r_rd.l), k_cl, k_cr);
    assign k_t  = low_clip(KW'(r_rd.t), k_ct, k_cb);
    assign k_r  = high_clip(KW'(r_rd.r), k_cl, k_cr);
    assign k_b  = high_clip(KW'(r_rd.b), k_ct, k_cb);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_last_add = r_last_add;
        n_n        = r_n;
        n_i        = r_i;
        n_j        = r_j;
        n_live_end = r_live_end;
        n_again    = r_again;
        n_dead     = r_dead;
        n_cur      = r_cur;
        n_o_valid  = r_o_valid;
        n_o_l      = r_o_l;
        n_o_t      = r_o_t;
        n_o_r      = r_o_r;
        n_o_b      = r_o_b;
        n_o_empty  = r_o_empty;
        n_o_ovf    = r_o_ovf;
        n_o_last   = r_o_last;
        mem_we     = 1'b0;
        mem_wa     = r_count[IW-1:0];
        mem_wd     = add_rect;
        mem_ra     = r_i[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.cmd == CMD_ADD) begin
                    if (r_count != '0 && in_raw == r_last_add) begin
                        n_count = r_count;
                    end else if (r_count == CW'(MAX_RECTS)) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we     = 1'b1;
                        n_count    = r_count + CW'(1);
                        n_last_add = in_raw;
                    end
                end else if (in_acc) begin
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_o_empty = 1'b0;
                    n_o_ovf   = 1'b0;
                    n_o_last  = 1'b1;
                    if (r_ovf) begin
                        n_o_ovf   = 1'b1;
                        n_o_l     = COORD_BITS'(k_cl);
                        n_o_t     = COORD_BITS'(k_ct);
                        n_o_r     = COORD_BITS'(k_cr);
                        n_o_b     = COORD_BITS'(k_cb);
                        n_o_valid = 1'b1;
                        n_state   = S_OUT;
                    end else if (r_count == '0) begin
                        n_o_empty = 1'b1;
                        n_o_l     = '0;
                        n_o_t     = '0;
                        n_o_r     = '0;
                        n_o_b     = '0;
                        n_o_valid = 1'b1;
                        n_state   = S_OUT;
                    end else begin
                        n_n     = r_count;
                        n_i     = '0;
                        n_again = 1'b0;
                        n_dead  = '0;
                        n_state = S_LI;
                    end
                end
            end
            S_LI: begin
                if (r_i == r_n) begin
                    n_i     = '0;
                    n_again = 1'b0;
                    n_state = r_again ? S_LI : S_CI;
                end else if (r_dead[r_i[IW-1:0]]) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_state = S_LI2;
                end
            end
            S_LI2: begin
                n_cur   = r_rd;
                n_j     = '0;
                n_state = S_LJ;
            end
            S_LJ: begin
                mem_ra = r_j[IW-1:0];
                if (r_j == r_n) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_i[IW-1:0];
                    mem_wd  = r_cur;
                    n_i     = r_i + CW'(1);
                    n_state = S_LI;
                end else if (r_j == r_i || r_dead[r_j[IW-1:0]]) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_state = S_MJ;
                end
            end
            S_MJ: begin
                if (meets) begin
                    n_cur                  = merged;
                    n_dead[r_j[IW-1:0]]    = 1'b1;
                    n_again                = 1'b1;
                end
                n_j     = r_j + CW'(1);
                n_state = S_LJ;
            end
            S_CI: begin
                if (r_i == r_n) begin
                    n_i     = '0;
                    n_state = S_EI;
                end else if (r_dead[r_i[IW-1:0]]) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_live_end = r_i;
                    n_state    = S_CI2;
                end
            end
            S_CI2: begin
                n_cur   = r_rd;
                n_j     = r_i + CW'(1);
                n_state = S_CJ;
            end
            S_CJ: begin
                mem_ra = r_j[IW-1:0];
                if (r_j == r_n) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_CI;
                end else if (r_dead[r_j[IW-1:0]]) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_state = S_HJ;
                end
            end
            S_HJ: begin
                if (holds) begin
                    n_dead[r_j[IW-1:0]] = 1'b1;
                end
                n_j     = r_j + CW'(1);
                n_state = S_CJ;
            end
            S_EI: begin
                if (r_i == r_n) begin
                    n_state = S_IDLE;
                end else if (r_dead[r_i[IW-1:0]]) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_state = S_EI2;
                end
            end
            S_EI2: begin
                n_o_l     = COORD_BITS'(k_l);
                n_o_t     = COORD_BITS'(k_t);
                n_o_r     = COORD_BITS'(k_r);
                n_o_b     = COORD_BITS'(k_b);
                n_o_empty = 1'b0;
                n_o_ovf   = 1'b0;
                n_o_last  = (r_i == r_live_end);
                n_o_valid = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_o_valid = 1'b0;
                    n_i       = r_i + CW'(1);
                    n_state   = r_o_last ? S_IDLE : S_EI;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
            r_clip_l  <= CLIP_LEFT_RST;
            r_clip_t  <= CLIP_TOP_RST;
            r_clip_r  <= CLIP_RIGHT_RST;
            r_clip_b  <= CLIP_BOTTOM_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLIP_LEFT:   r_clip_l <= i_cfg_data;
                    CFG_CLIP_TOP:    r_clip_t <= i_cfg_data;
                    CFG_CLIP_RIGHT:  r_clip_r <= i_cfg_data;
                    CFG_CLIP_BOTTOM: r_clip_b <= i_cfg_data;
                    default:         r_clip_l <= r_clip_l;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_add <= n_last_add;
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_live_end <= n_live_end;
        r_again    <= n_again;
        r_dead     <= n_dead;
        r_cur      <= n_cur;
        r_o_l      <= n_o_l;
        r_o_t      <= n_o_t;
        r_o_r      <= n_o_r;
        r_o_b      <= n_o_b;
        r_o_empty  <= n_o_empty;
        r_o_ovf    <= n_o_ovf;
        r_o_last   <= n_o_last;
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.out_left   = r_o_l;
    assign o_out.out_top    = r_o_t;
    assign o_out.out_right  = r_o_r;
    assign o_out.out_bottom = r_o_b;
    assign o_out.is_empty   = r_o_empty;
    assign o_out.overflowed = r_o_ovf;
    assign o_out.is_last    = r_o_last;

    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid) else $error("item accepted while a result waits");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECTS)) else $error("rectangle count beyond store depth");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.is_empty || o_out.overflowed) |-> o_out.is_last)
        else $error("single result of a flush not marked last");

    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.cmd == CMD_FLUSH |=> !i_in.ready && r_count == '0)
        else $error("flush did not start or did not clear the store");

endmodule

/* tb/drc_checker.sv */
module drc_checker
    import drc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [DRC_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DRC_CFG_W-1:0]     i_cfg_data,
    drc_in_if                        i_in,
    drc_out_if                       i_out,
    output int                       o_fails,
    output int                       o_pending
);

    typedef struct {
        logic signed [DRC_COORD_BITS-1:0] left;
        logic signed [DRC_COORD_BITS-1:0] top;
        logic signed [DRC_COORD_BITS-1:0] right;
        logic signed [DRC_COORD_BITS-1:0] bottom;
        logic                             is_empty;
        logic                             overflowed;
        logic                             is_last;
    } area_t;

    typedef struct {
        longint l, t, r, b;
    } box_t;

    area_t  area_q[$];
    box_t   stored[DRC_MAX_RECTS];
    int     stored_cnt;
    bit     store_ovf;
    longint clip_l, clip_t, clip_r, clip_b;
    int     fails;

    assign o_fails   = fails;
    assign o_pending = area_q.size();

    function automatic bit boxes_meet(box_t a, box_t c);
        return a.l < c.r && c.l < a.r && a.t < c.b && c.t < a.b;
    endfunction

    function automatic bit box_covers(box_t a, box_t c);
        return a.l <= c.l && c.r <= a.r && a.t <= c.t && c.b <= a.b;
    endfunction

    function automatic longint clamp_low(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic longint clamp_high(longint x, longint lo, longint hi);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic void push_area(longint l, longint t, longint r, longint b,
                                      bit e, bit o, bit last);
        area_t a;
        a.left = l[DRC_COORD_BITS-1:0];
        a.top = t[DRC_COORD_BITS-1:0];
        a.right = r[DRC_COORD_BITS-1:0];
        a.bottom = b[DRC_COORD_BITS-1:0];
        a.is_empty = e;
        a.overflowed = o;
        a.is_last = last;
        area_q = {area_q, a};
    endfunction

    function automatic void add_rect(box_t nb);
        box_t p;
        if (stored_cnt > 0) begin
            p = stored[stored_cnt-1];
            if (p.l == nb.l && p.t == nb.t && p.r == nb.r && p.b == nb.b) return;
        end
        if (stored_cnt >= DRC_MAX_RECTS) begin
            store_ovf = 1'b1;
            return;
        end
        stored[stored_cnt] = nb;
        stored_cnt++;
    endfunction

    function automatic void flush_areas();
        box_t w[$];
        int   i;
        int   j;
        bit   again;
        if (store_ovf) begin
            push_area(clip_l, clip_t, clip_r, clip_b, 1'b0, 1'b1, 1'b1);
            stored_cnt = 0;
            store_ovf = 1'b0;
            return;
        end
        if (stored_cnt == 0) begin
            push_area(0, 0, 0, 0, 1'b1, 1'b0, 1'b1);
            return;
        end
        for (i = 0; i < stored_cnt; i++) begin
            w = {w, stored[i]};
            w[i].r += 1;
            w[i].b += 1;
        end
        stored_cnt = 0;
        do begin
            again = 1'b0;
            for (i = 0; i < w.size(); i++) begin
                j = 0;
                while (j < w.size()) begin
                    if (i != j && boxes_meet(w[i], w[j])) begin
                        if (w[j].l < w[i].l) w[i].l = w[j].l;
                        if (w[j].t < w[i].t) w[i].t = w[j].t;
                        if (w[j].r > w[i].r) w[i].r = w[j].r;
                        if (w[j].b > w[i].b) w[i].b = w[j].b;
                        w.delete(j);
                        if (j < i) i--;
                        again = 1'b1;
                    end else begin
                        j++;
                    end
                end
            end
        end while (again);
        for (i = 0; i < w.size(); i++) begin
            j = i + 1;
            while (j < w.size()) begin
                if (box_covers(w[i], w[j])) w.delete(j);
                else j++;
            end
        end
        foreach (w[k]) begin
            push_area(clamp_low(w[k].l, clip_l, clip_r), clamp_low(w[k].t, clip_t, clip_b),
                      clamp_high(w[k].r, clip_l, clip_r), clamp_high(w[k].b, clip_t, clip_b),
                      1'b0, 1'b0, k == w.size() - 1);
        end
    endfunction

    always @(posedge i_clk) begin
        area_t a;
        box_t  nb;
        if (!i_rst_n) begin
            clip_l = CLIP_LEFT_RST;
            clip_t = CLIP_TOP_RST;
            clip_r = CLIP_RIGHT_RST;
            clip_b = CLIP_BOTTOM_RST;
            stored_cnt = 0;
            store_ovf = 1'b0;
            area_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLIP_LEFT:   clip_l = i_cfg_data;
                    CFG_CLIP_TOP:    clip_t = i_cfg_data;
                    CFG_CLIP_RIGHT:  clip_r = i_cfg_data;
                    CFG_CLIP_BOTTOM: clip_b = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.cmd == CMD_ADD) begin
                    nb.l = i_in.rect_left;
                    nb.t = i_in.rect_top;
                    nb.r = i_in.rect_right;
                    nb.b = i_in.rect_bottom;
                    add_rect(nb);
                end else begin
                    flush_areas();
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (area_q.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fails++;
                end else begin
                    a = area_q.pop_front();
                    if (a.is_empty !== i_out.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", a.is_empty, i_out.is_empty);
                        fails++;
                    end
                    if (a.overflowed !== i_out.overflowed) begin
                        $error("overflowed: expected %0d, got %0d", a.overflowed,
                               i_out.overflowed);
                        fails++;
                    end
                    if (a.is_last !== i_out.is_last) begin
                        $error("is_last: expected %0d, got %0d", a.is_last, i_out.is_last);
                        fails++;
                    end
                    if (!a.is_empty) begin
                        if (a.left !== i_out.out_left) begin
                            $error("out_left: expected %0d, got %0d", a.left, i_out.out_left);
                            fails++;
                        end
                        if (a.top !== i_out.out_top) begin
                            $error("out_top: expected %0d, got %0d", a.top, i_out.out_top);
                            fails++;
                        end
                        if (a.right !== i_out.out_right) begin
                            $error("out_right: expected %0d, got %0d", a.right,
                                   i_out.out_right);
                            fails++;
                        end
                        if (a.bottom !== i_out.out_bottom) begin
                            $error("out_bottom: expected %0d, got %0d", a.bottom,
                                   i_out.out_bottom);
                            fails++;
                        end
                    end else if (i_out.out_left !== 0 || i_out.out_top !== 0 ||
                                 i_out.out_right !== 0 || i_out.out_bottom !== 0) begin
                        $error("empty edges: expected 0, got %0d %0d %0d %0d", i_out.out_left,
                               i_out.out_top, i_out.out_right, i_out.out_bottom);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

/* tb/dirty_rect_coalescer_tb.sv */
module dirty_rect_coalescer_tb;
    import drc_pkg::*;

    localparam int IDLE_LIMIT = 400000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [DRC_CFG_IDX_W-1:0] cfg_idx;
    logic [DRC_CFG_W-1:0]     cfg_data;
    int                       fails;
    int                       pending;
    int                       idle_cycles;
    bit                       hold_req = 1'b0;

    drc_in_if  #(.COORD_BITS(DRC_COORD_BITS)) in_ch ();
    drc_out_if #(.COORD_BITS(DRC_COORD_BITS)) out_ch ();

    dirty_rect_coalescer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    drc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The sink stalls a random amount per item, and once holds off for a long stretch.
    initial begin
        int w;
        bit held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            w = $urandom_range(0, 4);
            if (hold_req && !held) begin
                w = 600;
                held = 1'b1;
            end
            repeat (w) @(negedge i_clk) out_ch.ready <= 1'b0;
            @(negedge i_clk) out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send(logic cmd, logic signed [DRC_COORD_BITS-1:0] l,
                        logic signed [DRC_COORD_BITS-1:0] t,
                        logic signed [DRC_COORD_BITS-1:0] r,
                        logic signed [DRC_COORD_BITS-1:0] b);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(negedge i_clk) in_ch.valid <= 1'b0;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.rect_left <= l;
        in_ch.rect_top <= t;
        in_ch.rect_right <= r;
        in_ch.rect_bottom <= b;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic add_rect(int l, int t, int r, int b);
        send(CMD_ADD, DRC_COORD_BITS'(l), DRC_COORD_BITS'(t), DRC_COORD_BITS'(r),
             DRC_COORD_BITS'(b));
    endtask

    task automatic flush();
        send(CMD_FLUSH, DRC_COORD_BITS'($urandom), DRC_COORD_BITS'($urandom),
             DRC_COORD_BITS'($urandom), DRC_COORD_BITS'($urandom));
    endtask

    task automatic add_random();
        int l, t;
        if ($urandom_range(0, 9) < 7) begin
            l = $urandom_range(0, 760) - 60;
            t = $urandom_range(0, 580) - 60;
            add_rect(l, t, l + $urandom_range(0, 130) - 6, t + $urandom_range(0, 130) - 6);
        end else begin
            add_rect($urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic drain();
        @(negedge i_clk) in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_clip(int l, int t, int r, int b);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_CLIP_LEFT;
        cfg_data <= DRC_CFG_W'(l);
        @(negedge i_clk) cfg_idx <= CFG_CLIP_TOP;
        cfg_data <= DRC_CFG_W'(t);
        @(negedge i_clk) cfg_idx <= CFG_CLIP_RIGHT;
        cfg_data <= DRC_CFG_W'(r);
        @(negedge i_clk) cfg_idx <= CFG_CLIP_BOTTOM;
        cfg_data <= DRC_CFG_W'(b);
        @(negedge i_clk) cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int items);
        int n;
        int sent;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 6);
            repeat (n) add_random();
            if ($urandom_range(0, 3) == 0) begin
                add_rect($urandom, $urandom, $urandom, $urandom);
                sent++;
            end
            flush();
            sent += n + 1;
        end
    endtask

    initial begin
        cfg_we = 1'b0;
        cfg_idx = CFG_CLIP_LEFT;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_ADD;
        in_ch.rect_left = '0;
        in_ch.rect_top = '0;
        in_ch.rect_right = '0;
        in_ch.rect_bottom = '0;
        @(posedge i_rst_n);
        @(posedge i_clk);

        flush();
        add_rect(-32768, -32768, 32767, 32767);
        add_rect(-32768, -32768, 32767, 32767);
        add_rect(32767, 32767, -32768, -32768);
        add_rect(100, 100, 100, 100);
        add_rect(10, 10, 50, 50);
        add_rect(50, 50, 80, 80);
        add_rect(20, 20, 30, 30);
        add_rect(600, 400, 700, 500);
        flush();
        add_rect(5, 5, 5, 5);
        flush();
        drain();

        for (int k = 0; k < 33; k++) add_rect(k * 20, 0, k * 20 + 5, 5);
        flush();
        drain();

        write_clip(0, 0, 32767, 32767);
        random_phase(50);
        drain();

        write_clip(32767, 32767, 0, 0);
        random_phase(30);
        drain();

        write_clip($urandom_range(0, 100), $urandom_range(0, 100),
                   $urandom_range(300, 700), $urandom_range(200, 500));
        for (int k = 0; k < 12; k++) add_rect(k * 7, k * 3, k * 7 + 40, k * 3 + 40);
        hold_req = 1'b1;
        flush();
        random_phase(80);
        drain();

        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
